// ===== rtl/cats_pkg.sv =====
// Shared constants, types and engine states for the closest-approach search core.
`default_nettype none
package cats_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_COORDS     = 8;
   localparam int OUT_W          = 33;
   localparam int OUT_BYTES_W    = 40;
   localparam int CFG_W          = 8;
   localparam int DIV_DIGITS     = 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam logic [CFG_W-1:0] ITER_RESET = 8'd48;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_MUL,
      ENG_DECIDE,
      ENG_SPLIT,
      ENG_LOAD,
      ENG_PICK,
      ENG_ROOT,
      ENG_OUT
   } eng_state_type;

   typedef struct packed {
      eng_state_type    state;
      logic [CFG_W-1:0] iters;
   } eng_stat_type;

endpackage
`default_nettype wire

// ===== rtl/closest_approach_ternary_search_core.sv =====
// Top level of the closest-approach ternary search core.
//
//  channel | ports            | payload
//  --------+------------------+-----------------------------------------------
//  request | req_t*           | eight signed coordinates, COORD_BITS each
//  result  | rsp_t*           | min_distance, 33 bit unsigned, FRAC_BITS frac
//  csr     | csr_we/csr_wdata | iteration_count, 8 bit
//
// Each narrowing step uses the eight split lanes (eight quotient bits per
// cycle) and the one shared squarer (four squares); the root runs one bit per cycle.
// A two-entry queue lets the input stage take requests while the engine
// works; the result register holds a result while the engine moves on.
// Synchronous reset clears all handshake and sequencer state; the register
// returns to 48.
`default_nettype none
module closest_approach_ternary_search_core import cats_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // start_one_x, start_one_y, end_one_x, end_one_y,
   // start_two_x, start_two_y, end_two_x, end_two_y (lowest first)
   input  wire logic [NUM_COORDS*COORD_BITS-1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // min_distance [32:0], zero fill above
   output logic [OUT_BYTES_W-1:0]                    rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [CFG_W-1:0]                     csr_wdata
);
   localparam int W = COORD_BITS + FRAC_BITS;

   logic [CFG_W-1:0]        iter_cnt_ff;
   logic                    rsp_valid_ff;
   logic [OUT_W-1:0]        rsp_data_ff;

   logic                    push, full, empty, pop;
   logic [NUM_COORDS*W-1:0] push_data, head;
   logic                    out_load, out_busy;
   logic [OUT_W-1:0]        out_value;
   eng_stat_type            eng_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_cnt_ff <= ITER_RESET;
      end else if (csr_we) begin
         iter_cnt_ff <= csr_wdata;
      end
   end

   cats_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .push(push), .push_data(push_data), .full(full)
   );

   cats_queue #(.WIDTH(NUM_COORDS*W)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .pop(pop),
      .head(head), .full(full), .empty(empty)
   );

   cats_engine #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_engine (
      .clock(clock), .reset(reset),
      .q_valid(!empty), .q_data(head), .q_pop(pop),
      .iteration_count(iter_cnt_ff),
      .out_busy(out_busy), .out_load(out_load), .out_value(out_value),
      .stat(eng_stat)
   );

   // result register: engine may load it in the cycle the old result leaves
   assign out_busy = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_BYTES_W-OUT_W){1'b0}}, rsp_data_ff};

   // a new result only appears out of the sequencer's output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(eng_stat.state) == ENG_OUT)
      else $error("result raised outside output state");

   // a split never starts with the step budget used up
   a_split_budget: assert property (@(posedge clock) disable iff (reset)
      eng_stat.state == ENG_SPLIT |-> eng_stat.iters != '0)
      else $error("split with no steps left");

   // an idle engine takes a queued request at once
   a_idle_pops: assert property (@(posedge clock) disable iff (reset)
      (eng_stat.state == ENG_IDLE && !empty) |=> eng_stat.state == ENG_MUL)
      else $error("idle engine missed a queued request");

   // the queue never takes a request while full
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

endmodule
`default_nettype wire

// ===== rtl/cats_front.sv =====
// Input stage: takes requests and converts coordinates to fixed point.
`default_nettype none
module cats_front import cats_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [NUM_COORDS*COORD_BITS-1:0]          req_tdata,
   output logic                                           push,
   output logic [NUM_COORDS*(COORD_BITS+FRAC_BITS)-1:0]   push_data,
   input  wire logic                                      full
);
   localparam int W = COORD_BITS + FRAC_BITS;

   logic                      fv_ff;
   logic [NUM_COORDS*W-1:0]   data_ff;
   logic [NUM_COORDS*W-1:0]   conv;

   // integer coordinate -> Q(COORD_BITS).FRAC_BITS
   always_comb begin
      for (int i = 0; i < NUM_COORDS; i++) begin
         conv[i*W +: W] = {req_tdata[i*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
      end
   end

   assign push       = fv_ff && !full;
   assign req_tready = !fv_ff || !full;
   assign push_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         fv_ff <= 1'b1;
      end else if (push) begin
         fv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= conv;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cats_queue.sv =====
// Two-entry queue between the input stage and the search engine.
`default_nettype none
module cats_queue import cats_pkg::*; #(
   parameter int WIDTH = NUM_COORDS * (COORD_BITS_DEF + FRAC_BITS_DEF)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head,
   output logic                  full,
   output logic                  empty
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff;
   logic [PTR_W-1:0] rd_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cats_div3.sv =====
// One split lane: floor((2*near + far) / 3), eight quotient bits per cycle.
`default_nettype none
module cats_div3 import cats_pkg::*; #(
   parameter int W = COORD_BITS_DEF + FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                start,
   input  wire logic                step,
   input  wire logic signed [W-1:0] near_pt,
   input  wire logic signed [W-1:0] far_pt,
   output logic signed [W-1:0]      quo
);
   localparam int N_W     = W + 2;
   localparam int DIV_CYC = (N_W + DIV_DIGITS - 1) / DIV_DIGITS;
   localparam int DIV_W   = DIV_CYC * DIV_DIGITS;

   logic             neg_ff;
   logic [DIV_W-1:0] sh_ff;
   logic [DIV_W-1:0] q_ff;
   logic [1:0]       rem_ff;
   logic [N_W-1:0]   sum;
   logic [N_W-1:0]   mag;
   logic [N_W-1:0]   qm;
   logic [N_W-1:0]   qs;
   logic [1:0]       rem_nx;
   logic [2:0]       r3;
   logic [DIV_DIGITS-1:0] qbits;

   assign sum = {near_pt[W-1], near_pt, 1'b0} + {{2{far_pt[W-1]}}, far_pt};
   // negative: floor(n/3) = -((-n + 2) / 3)
   assign mag = sum[N_W-1] ? (~sum + N_W'(3)) : sum;

   always_comb begin
      rem_nx = rem_ff;
      qbits  = '0;
      r3     = '0;
      for (int k = 0; k < DIV_DIGITS; k++) begin
         r3 = {rem_nx, sh_ff[DIV_W-1-k]};
         if (r3 >= 3'd3) begin
            r3 = r3 - 3'd3;
            qbits[DIV_DIGITS-1-k] = 1'b1;
         end
         rem_nx = r3[1:0];
      end
   end

   assign qm  = q_ff[N_W-1:0];
   assign qs  = neg_ff ? (~qm + 1'b1) : qm;
   assign quo = qs[W-1:0];

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= sum[N_W-1];
         sh_ff  <= DIV_W'(mag);
         q_ff   <= '0;
         rem_ff <= '0;
      end else if (step) begin
         sh_ff  <= sh_ff << DIV_DIGITS;
         q_ff   <= {q_ff[DIV_W-DIV_DIGITS-1:0], qbits};
         rem_ff <= rem_nx;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cats_sqrt.sv =====
// Bit-serial floor square root, one result bit per cycle.
`default_nettype none
module cats_sqrt import cats_pkg::*; #(
   parameter int W = COORD_BITS_DEF + FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [2*W:0]     radicand,
   output logic                  done,
   output logic [W:0]            root
);
   localparam int ROOT_W = W + 1;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = W + 4;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W-1:0]  rem2;
   logic [REM_W-1:0]  trial;
   logic              fit;

   assign rem2  = {rem_ff[W+1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign fit   = (rem2 >= trial);
   assign done  = done_ff;
   assign root  = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == CNT_W'(ROOT_W - 1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= RAD_W'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fit ? (rem2 - trial) : rem2;
         root_ff <= {root_ff[ROOT_W-2:0], fit};
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cats_engine.sv =====
// Search engine: split lanes, shared squarer, narrowing control and square root.
`default_nettype none
module cats_engine import cats_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic                                             q_valid,
   input  wire logic [NUM_COORDS*(COORD_BITS+FRAC_BITS)-1:0]     q_data,
   output logic                                                  q_pop,
   input  wire logic [CFG_W-1:0]                                 iteration_count,
   input  wire logic                                             out_busy,
   output logic                                                  out_load,
   output logic [OUT_W-1:0]                                      out_value,
   output eng_stat_type                                          stat
);
   localparam int W       = COORD_BITS + FRAC_BITS;
   localparam int SQ_W    = 2 * W + 1;
   localparam int ROOT_W  = W + 1;
   localparam int EXT_W   = ROOT_W + OUT_W;
   localparam int DIV_CYC = (W + 2 + DIV_DIGITS - 1) / DIV_DIGITS;
   localparam int DCNT_W  = $clog2(DIV_CYC + 1);

   eng_state_type state_ff, state_in;

   // per axis (0 = x, 1 = y): interval ends of both segments
   logic signed [W-1:0] s1lo_ff [2];
   logic signed [W-1:0] s1hi_ff [2];
   logic signed [W-1:0] s2lo_ff [2];
   logic signed [W-1:0] s2hi_ff [2];
   // probe points: [0..1] first pair x/y, [2..3] second pair x/y
   logic signed [W-1:0] pa_ff [4];
   logic signed [W-1:0] pb_ff [4];
   logic signed [W-1:0] lane_a [4];
   logic signed [W-1:0] lane_b [4];

   logic [SQ_W-1:0]   dlo_ff, dhi_ff, s0_ff, s1_ff;
   logic [W-1:0]      mag_ff;
   logic [2*W-1:0]    prod_ff;
   logic [2:0]        ph_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [CFG_W-1:0]  iters_ff;
   logic              init_ff;

   logic              div_start, div_step, sq_start, last_step;
   logic signed [W:0] diff;
   logic [W:0]        diff_abs;
   logic [SQ_W-1:0]   best;
   logic              sq_done;
   logic [W:0]        sq_root;
   logic [EXT_W-1:0]  root_ext;

   genvar j;
   generate
      for (j = 0; j < 2; j++) begin : g_axis
         cats_div3 #(.W(W)) u_a1 (.clock(clock), .start(div_start), .step(div_step),
            .near_pt(s1lo_ff[j]), .far_pt(s1hi_ff[j]), .quo(lane_a[j]));
         cats_div3 #(.W(W)) u_a2 (.clock(clock), .start(div_start), .step(div_step),
            .near_pt(s1hi_ff[j]), .far_pt(s1lo_ff[j]), .quo(lane_a[2+j]));
         cats_div3 #(.W(W)) u_b1 (.clock(clock), .start(div_start), .step(div_step),
            .near_pt(s2lo_ff[j]), .far_pt(s2hi_ff[j]), .quo(lane_b[j]));
         cats_div3 #(.W(W)) u_b2 (.clock(clock), .start(div_start), .step(div_step),
            .near_pt(s2hi_ff[j]), .far_pt(s2lo_ff[j]), .quo(lane_b[2+j]));
      end
   endgenerate

   assign best = (dlo_ff <= dhi_ff) ? dlo_ff : dhi_ff;

   cats_sqrt #(.W(W)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(best),
      .done(sq_done), .root(sq_root)
   );

   assign last_step = init_ff ? (iters_ff == '0) : (iters_ff == CFG_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE:   if (q_valid) state_in = ENG_MUL;
         ENG_MUL:    if (ph_ff == 3'd5) state_in = ENG_DECIDE;
         ENG_DECIDE: state_in = last_step ? ENG_PICK : ENG_SPLIT;
         ENG_SPLIT:  if (dcnt_ff == DCNT_W'(DIV_CYC)) state_in = ENG_LOAD;
         ENG_LOAD:   state_in = ENG_MUL;
         ENG_PICK:   state_in = ENG_ROOT;
         ENG_ROOT:   if (sq_done) state_in = ENG_OUT;
         ENG_OUT:    if (!out_busy) state_in = ENG_IDLE;
         default:    state_in = ENG_IDLE;
      endcase
   end

   // control strobes; lanes start in the first split cycle, after the
   // interval ends have been narrowed
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      div_step  = 1'b0;
      sq_start  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ENG_IDLE:   q_pop = q_valid;
         ENG_SPLIT: begin
            div_start = (dcnt_ff == '0);
            div_step  = (dcnt_ff != '0);
         end
         ENG_PICK:   sq_start = 1'b1;
         ENG_OUT:    out_load = !out_busy;
         default:    q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign diff     = {pa_ff[ph_ff[1:0]][W-1], pa_ff[ph_ff[1:0]]}
                   - {pb_ff[ph_ff[1:0]][W-1], pb_ff[ph_ff[1:0]]};
   assign diff_abs = diff[W] ? (~diff + 1'b1) : diff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int a = 0; a < 2; a++) begin
            s1lo_ff[a] <= q_data[(0+a)*W +: W];
            s1hi_ff[a] <= q_data[(2+a)*W +: W];
            s2lo_ff[a] <= q_data[(4+a)*W +: W];
            s2hi_ff[a] <= q_data[(6+a)*W +: W];
            pa_ff[a]   <= q_data[(0+a)*W +: W];
            pa_ff[2+a] <= q_data[(2+a)*W +: W];
            pb_ff[a]   <= q_data[(4+a)*W +: W];
            pb_ff[2+a] <= q_data[(6+a)*W +: W];
         end
         iters_ff <= iteration_count;
         init_ff  <= 1'b1;
         ph_ff    <= '0;
      end
      if (state_ff == ENG_LOAD) begin
         for (int a = 0; a < 4; a++) begin
            pa_ff[a] <= lane_a[a];
            pb_ff[a] <= lane_b[a];
         end
         ph_ff <= '0;
      end
      if (state_ff == ENG_DECIDE) begin
         dcnt_ff <= '0;
      end else if (state_ff == ENG_SPLIT) begin
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (state_ff == ENG_MUL) begin
         ph_ff <= ph_ff + 1'b1;
         if (ph_ff < 3'd4) begin
            mag_ff <= diff_abs[W-1:0];
         end
         if (ph_ff >= 3'd1 && ph_ff <= 3'd4) begin
            prod_ff <= mag_ff * mag_ff;
         end
         case (ph_ff)
            3'd2:    s0_ff <= SQ_W'(prod_ff);
            3'd3:    s0_ff <= s0_ff + SQ_W'(prod_ff);
            3'd4:    s1_ff <= SQ_W'(prod_ff);
            3'd5:    s1_ff <= s1_ff + SQ_W'(prod_ff);
            default: s0_ff <= s0_ff;
         endcase
      end
      if (state_ff == ENG_DECIDE) begin
         init_ff <= 1'b0;
         if (init_ff) begin
            dlo_ff <= s0_ff;
            dhi_ff <= s1_ff;
         end else begin
            iters_ff <= iters_ff - 1'b1;
            if (s0_ff <= s1_ff) begin
               dhi_ff <= s1_ff;
               for (int a = 0; a < 2; a++) begin
                  s1hi_ff[a] <= pa_ff[2+a];
                  s2hi_ff[a] <= pb_ff[2+a];
               end
            end else begin
               dlo_ff <= s0_ff;
               for (int a = 0; a < 2; a++) begin
                  s1lo_ff[a] <= pa_ff[a];
                  s2lo_ff[a] <= pb_ff[a];
               end
            end
         end
      end
   end

   // saturate the root to the result width
   assign root_ext  = EXT_W'(sq_root);
   assign out_value = (root_ext > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                         : root_ext[OUT_W-1:0];

   assign stat.state = state_ff;
   assign stat.iters = iters_ff;

endmodule
`default_nettype wire

// ===== test/closest_approach_ternary_search_core_tb.sv =====
// Self-checking bench for the closest-approach ternary search core.
`timescale 1ns / 100ps
`default_nettype none
module closest_approach_ternary_search_core_tb;
   import cats_pkg::*;

   localparam int CB = 16;
   localparam int FB = 16;
   localparam logic [32:0] DIST_MAX = 33'h1FFFFFFFF;

   typedef logic [NUM_COORDS*CB-1:0] seg_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // start_one_x, start_one_y, end_one_x, end_one_y,
   // start_two_x, start_two_y, end_two_x, end_two_y (lowest first)
   seg_pair_type req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // min_distance [32:0], zero fill above
   logic [OUT_BYTES_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   closest_approach_ternary_search_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   seg_pair_type pending_reqs[$];
   logic [32:0] expected_dist[$];
   logic [CFG_W-1:0] step_count = ITER_RESET;
   int errors = 0;
   int hold_cycles = 0;   // long receiver stall request

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor: fixed-point ternary search on 128-bit squares.
   function automatic logic signed [47:0] third_floor(logic signed [47:0] n);
      if (n >= 0) begin
         return n / 3;
      end
      return -((-n + 2) / 3);
   endfunction

   function automatic logic [127:0] sq_gap(logic signed [47:0] ax, logic signed [47:0] ay,
                                           logic signed [47:0] bx, logic signed [47:0] by);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0] mx;
      logic [63:0] my;
      dx = ax - bx;
      dy = ay - by;
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      return 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
   endfunction

   function automatic logic [32:0] closest_distance(seg_pair_type seg,
                                                    logic [CFG_W-1:0] steps);
      logic signed [47:0] c[8];
      logic signed [47:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
      logic [127:0] d_lo, d_hi, da, db, best;
      logic [63:0] root, cand;
      for (int i = 0; i < 8; i++) begin
         c[i] = 48'(signed'(seg[i*CB +: CB])) <<< FB;
      end
      d_lo = sq_gap(c[0], c[1], c[4], c[5]);
      d_hi = sq_gap(c[2], c[3], c[6], c[7]);
      for (int k = 0; k < steps; k++) begin
         a1x = third_floor(2 * c[0] + c[2]); a1y = third_floor(2 * c[1] + c[3]);
         a2x = third_floor(2 * c[2] + c[0]); a2y = third_floor(2 * c[3] + c[1]);
         b1x = third_floor(2 * c[4] + c[6]); b1y = third_floor(2 * c[5] + c[7]);
         b2x = third_floor(2 * c[6] + c[4]); b2y = third_floor(2 * c[7] + c[5]);
         da = sq_gap(a1x, a1y, b1x, b1y);
         db = sq_gap(a2x, a2y, b2x, b2y);
         if (da <= db) begin
            d_hi = db; c[2] = a2x; c[3] = a2y; c[6] = b2x; c[7] = b2y;
         end else begin
            d_lo = da; c[0] = a1x; c[1] = a1y; c[4] = b1x; c[5] = b1y;
         end
      end
      best = d_lo <= d_hi ? d_lo : d_hi;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= best) root = cand;
      end
      return root > 64'(DIST_MAX) ? DIST_MAX : root[32:0];
   endfunction

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 20) - 10);
         default: return 16'($urandom);
      endcase
   endfunction

   // Driver: idle gap drawn per request.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_dist.push_back(closest_distance(req_tdata, step_count));
         end
         if (req_tvalid && !req_tready) begin
            // hold request
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_tdata <= pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: compare results, draw stalls.
   int recv_gap = 0;
   always @(posedge clock) begin
      logic [32:0] exp_d;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dist.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               errors++;
            end else begin
               exp_d = expected_dist.pop_front();
               if (rsp_tdata !== {7'd0, exp_d}) begin
                  $display("%0t: min_distance expected %h actual %h",
                           $time, exp_d, rsp_tdata);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_dist.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_steps(logic [CFG_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      step_count = v;
   endtask

   task automatic queue_random(int n);
      seg_pair_type s;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < 8; j++) s[j*CB +: CB] = rand_coord();
         if ($urandom_range(0, 7) == 0) s[4*CB +: 2*CB] = s[0 +: 2*CB];
         if ($urandom_range(0, 7) == 0) s[2*CB +: 2*CB] = s[0 +: 2*CB];
         pending_reqs.push_back(s);
      end
   endtask

   initial begin
      logic [CFG_W-1:0] step_set[6];
      step_set = '{8'd0, 8'd1, 8'd255, 8'd5, 8'd20, 8'd48};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, zero-length segments, crossing paths.
      pending_reqs.push_back('0);
      pending_reqs.push_back({8{16'h7FFF}});
      pending_reqs.push_back({8{16'h8000}});
      pending_reqs.push_back({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
      pending_reqs.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      pending_reqs.push_back({16'd0, 16'd10, 16'd10, 16'd0, 16'd10, 16'd10, 16'd0, 16'd0});
      pending_reqs.push_back({16'd5, 16'd5, 16'd5, 16'd5, 16'hFFFD, 16'd7, 16'hFFFD, 16'd7});
      pending_reqs.push_back({16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
                              16'hAAAA, 16'h5555, 16'h0001, 16'hFFFF});
      drain();
      foreach (step_set[i]) begin
         set_steps(step_set[i]);
         if (i == 0) begin
            pending_reqs.push_back({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                    16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
            pending_reqs.push_back({8{16'h8000}});
         end
         queue_random(i < 3 ? 60 : 500);
         if (i == 4) begin
            // Long receiver stall while requests keep coming.
            repeat (30) @(posedge clock);
            hold_cycles = 3000;
         end
         drain();
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/cats_pkg.sv
rtl/cats_front.sv
rtl/cats_queue.sv
rtl/cats_div3.sv
rtl/cats_sqrt.sv
rtl/cats_engine.sv
rtl/closest_approach_ternary_search_core.sv
test/closest_approach_ternary_search_core_tb.sv
